>>> rtl/cascaded_incremental_pid_top_assert.svh
// Assertion macros shared by the checker of the cascaded PID block.
`ifndef CASCADED_INCREMENTAL_PID_TOP_ASSERT_SVH
`define CASCADED_INCREMENTAL_PID_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CIP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cascaded_incremental_pid_top: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CIP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cascaded_incremental_pid_top: assertion failed");

`endif

>>> rtl/cip_pkg.sv
package cip_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned RPM_W     = 16;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned LIMIT_W   = 31;
  localparam int unsigned ERR_W     = 33;
  localparam int unsigned OPND_W    = 35;
  localparam int unsigned LO_W      = 18;
  localparam int unsigned MUL_A_W   = GAIN_W + 1;
  localparam int unsigned MUL_B_W   = LO_W + 1;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned SUM_W     = 63;
  localparam int unsigned WIDE_W    = 64;
  localparam int unsigned S_TDATA_W = 80;
  localparam int unsigned M_TDATA_W = 64;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned STEP_W    = 4;

  localparam logic OP_POSITION = 1'b0;
  localparam logic OP_SPEED    = 1'b1;

  localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_KP    = 8'd0,
    CFG_POS_KI    = 8'd1,
    CFG_POS_KD    = 8'd2,
    CFG_SPD_KP    = 8'd3,
    CFG_SPD_KI    = 8'd4,
    CFG_SPD_KD    = 8'd5,
    CFG_POS_LIMIT = 8'd6,
    CFG_SPD_LIMIT = 8'd7
  } cfg_idx_e;

  typedef enum logic {
    LOOP_POS = 1'b0,
    LOOP_SPD = 1'b1
  } loop_e;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } term_e;

  typedef enum logic {
    JMP_NEXT   = 1'b0,
    JMP_BRANCH = 1'b1
  } jump_e;

  typedef struct packed {
    logic  sum_clr;
    logic  err_en;
    logic  diff_en;
    logic  mul_en;
    term_e term;
    logic  mul_hi;
    logic  acc_en;
    logic  add_en;
    logic  clamp_en;
    jump_e jump;
  } ctl_t;

  localparam logic [STEP_W-1:0] STEP_ERR   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DIFF  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_P_LO  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_P_HI  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_I_LO  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_I_HI  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_D_LO  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_D_HI  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_ACC   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_ADD   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_CLAMP = 4'd10;

  // Microprogram for one loop. Each multiply step but the first also accumulates the
  // product registered by the step before it.
  function automatic ctl_t ctl_rom(logic [STEP_W-1:0] step);
    ctl_t w;
    w = '0;
    case (step)
      STEP_ERR: begin
        w.err_en  = 1'b1;
        w.sum_clr = 1'b1;
      end
      STEP_DIFF: w.diff_en = 1'b1;
      STEP_P_LO: begin
        w.mul_en = 1'b1;
        w.term   = TERM_P;
      end
      STEP_P_HI: begin
        w.mul_en = 1'b1;
        w.term   = TERM_P;
        w.mul_hi = 1'b1;
        w.acc_en = 1'b1;
      end
      STEP_I_LO: begin
        w.mul_en = 1'b1;
        w.term   = TERM_I;
        w.acc_en = 1'b1;
      end
      STEP_I_HI: begin
        w.mul_en = 1'b1;
        w.term   = TERM_I;
        w.mul_hi = 1'b1;
        w.acc_en = 1'b1;
      end
      STEP_D_LO: begin
        w.mul_en = 1'b1;
        w.term   = TERM_D;
        w.acc_en = 1'b1;
      end
      STEP_D_HI: begin
        w.mul_en = 1'b1;
        w.term   = TERM_D;
        w.mul_hi = 1'b1;
        w.acc_en = 1'b1;
      end
      STEP_ACC: w.acc_en = 1'b1;
      STEP_ADD: w.add_en = 1'b1;
      STEP_CLAMP: begin
        w.clamp_en = 1'b1;
        w.jump     = JMP_BRANCH;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/cip_seq.sv
module cip_seq
  import cip_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  op_i,
  input  logic  out_full_i,
  output ctl_t  ctl_o,
  output loop_e loop_o,
  output logic  busy_o,
  output logic  done_o
);

  logic [STEP_W-1:0] pc_q, pc_d;
  loop_e             loop_q, loop_d;
  logic              busy_q, busy_d;
  ctl_t              word;
  logic              stall;

  assign word  = ctl_rom(pc_q);
  assign stall = busy_q && (word.jump == JMP_BRANCH) && (loop_q == LOOP_SPD) && out_full_i;

  always_comb begin
    pc_d   = pc_q;
    loop_d = loop_q;
    busy_d = busy_q;
    ctl_o  = '0;
    done_o = 1'b0;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d   = STEP_ERR;
        loop_d = (op_i == OP_SPEED) ? LOOP_SPD : LOOP_POS;
      end
    end else if (!stall) begin
      ctl_o = word;
      case (word.jump)
        JMP_NEXT: pc_d = pc_q + 1'b1;
        JMP_BRANCH: begin
          if (loop_q == LOOP_POS) begin
            loop_d = LOOP_SPD;
            pc_d   = STEP_ERR;
          end else begin
            busy_d = 1'b0;
            done_o = 1'b1;
          end
        end
        default: pc_d = STEP_ERR;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= STEP_ERR;
      loop_q <= LOOP_POS;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      loop_q <= loop_d;
      busy_q <= busy_d;
    end
  end

  assign loop_o = loop_q;
  assign busy_o = busy_q;

endmodule

>>> rtl/cascaded_incremental_pid_top.sv
// Cascaded position/speed incremental PID. One request carries op (tuser),
// target, measured angle and measured rpm; one result carries the clamped
// speed loop output (drive) and the stored position loop output. A small
// microprogram runs each loop on one shared 25x19 multiplier (six partial
// products per loop): a speed-only request runs the speed loop alone, and a
// position request runs the position loop and then the speed loop.
// The next request is accepted in the cycle after the result register loads,
// even while that result still waits downstream. Gains and limits are to be
// written through the cfg port while the block is idle; the block does not
// enforce it. Gains, limits, accumulators and histories reset to zero.
module cascaded_incremental_pid_top
  import cip_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // target [31:0], measured_angle [63:32], measured_rpm [79:64]
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // op [0]
  input  logic                 s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // drive [31:0], speed_command [63:32]
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned SW = (FRAC_BITS > 16) ? FRAC_BITS + 17 : ERR_W;

  logic [GAIN_W-1:0]  pos_kp_q, pos_ki_q, pos_kd_q, spd_kp_q, spd_ki_q, spd_kd_q;
  logic [LIMIT_W-1:0] pos_lim_q, spd_lim_q;

  logic                      op_q;
  logic signed [DATA_W-1:0]  target_q, angle_q;
  logic signed [RPM_W-1:0]   rpm_q;

  logic signed [DATA_W-1:0]  pos_accum_q, spd_accum_q;
  logic signed [ERR_W-1:0]   pos_e1_q, pos_e0_q, spd_e1_q, spd_e0_q;
  logic signed [ERR_W-1:0]   e_q;
  logic signed [OPND_W-1:0]  d1_q, d2_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic                      prod_hi_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic signed [WIDE_W-1:0]  wide_q;
  logic signed [DATA_W-1:0]  drive_q, cmd_q;
  logic                      out_valid_q;

  ctl_t  ctl;
  loop_e loop;
  logic  busy, done, accept;

  assign s_axis_tready_o = !busy;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  cip_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .op_i       (s_axis_tuser_i),
    .out_full_i (out_valid_q && !m_axis_tready_i),
    .ctl_o      (ctl),
    .loop_o     (loop),
    .busy_o     (busy),
    .done_o     (done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_kp_q  <= '0;
      pos_ki_q  <= '0;
      pos_kd_q  <= '0;
      spd_kp_q  <= '0;
      spd_ki_q  <= '0;
      spd_kd_q  <= '0;
      pos_lim_q <= '0;
      spd_lim_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_POS_KP:    pos_kp_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_POS_KI:    pos_ki_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_POS_KD:    pos_kd_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_SPD_KP:    spd_kp_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_SPD_KI:    spd_ki_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_SPD_KD:    spd_kd_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_POS_LIMIT: pos_lim_q <= cfg_data_i[LIMIT_W-1:0];
        CFG_SPD_LIMIT: spd_lim_q <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= s_axis_tuser_i;
      target_q <= s_axis_tdata_i[31:0];
      angle_q  <= s_axis_tdata_i[63:32];
      rpm_q    <= s_axis_tdata_i[79:64];
    end
  end

  // Error of the active loop, saturated to the history width.
  logic signed [ERR_W-1:0]  pos_diff;
  logic signed [DATA_W-1:0] sref;
  logic signed [SW-1:0]     fdb_w, err_raw;
  logic signed [ERR_W-1:0]  err_sat;

  assign pos_diff = ERR_W'(target_q) - ERR_W'(angle_q);
  assign sref     = (op_q == OP_SPEED) ? target_q : pos_accum_q;
  assign fdb_w    = SW'(rpm_q) <<< FRAC_BITS;
  assign err_raw  = (loop == LOOP_POS) ? SW'(pos_diff) : (SW'(sref) - fdb_w);

  always_comb begin
    if ((&err_raw[SW-1:ERR_W-1]) || !(|err_raw[SW-1:ERR_W-1])) begin
      err_sat = err_raw[ERR_W-1:0];
    end else if (err_raw[SW-1]) begin
      err_sat = ERR_MIN;
    end else begin
      err_sat = ERR_MAX;
    end
  end

  logic signed [ERR_W-1:0]  e1_sel, e0_sel;
  logic signed [DATA_W-1:0] accum_sel;
  logic [LIMIT_W-1:0]       lim_sel;

  assign e1_sel    = (loop == LOOP_POS) ? pos_e1_q : spd_e1_q;
  assign e0_sel    = (loop == LOOP_POS) ? pos_e0_q : spd_e0_q;
  assign accum_sel = (loop == LOOP_POS) ? pos_accum_q : spd_accum_q;
  assign lim_sel   = (loop == LOOP_POS) ? pos_lim_q : spd_lim_q;

  // Shared multiplier operands.
  logic [GAIN_W-1:0]         gain;
  logic signed [OPND_W-1:0]  opnd;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  always_comb begin
    case (ctl.term)
      TERM_P: begin
        gain = (loop == LOOP_POS) ? pos_kp_q : spd_kp_q;
        opnd = d1_q;
      end
      TERM_I: begin
        gain = (loop == LOOP_POS) ? pos_ki_q : spd_ki_q;
        opnd = OPND_W'(e_q);
      end
      TERM_D: begin
        gain = (loop == LOOP_POS) ? pos_kd_q : spd_kd_q;
        opnd = d2_q;
      end
      default: begin
        gain = '0;
        opnd = '0;
      end
    endcase
  end

  assign mul_a = signed'({1'b0, gain});
  assign mul_b = ctl.mul_hi ? MUL_B_W'(signed'(opnd[OPND_W-1:LO_W]))
                            : signed'({1'b0, opnd[LO_W-1:0]});
  assign prod  = mul_a * mul_b;

  logic signed [SUM_W-1:0]  addend;
  logic signed [WIDE_W-1:0] lim_w, clamp_w;

  assign addend = prod_hi_q ? (SUM_W'(prod_q) <<< LO_W) : SUM_W'(prod_q);
  assign lim_w  = signed'(WIDE_W'(lim_sel));

  always_comb begin
    if (wide_q > lim_w) begin
      clamp_w = lim_w;
    end else if (wide_q < -lim_w) begin
      clamp_w = -lim_w;
    end else begin
      clamp_w = wide_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.err_en) begin
      e_q <= err_sat;
    end
    if (ctl.diff_en) begin
      d1_q <= OPND_W'(e_q) - OPND_W'(e1_sel);
      d2_q <= OPND_W'(e_q) - (OPND_W'(e1_sel) <<< 1) + OPND_W'(e0_sel);
    end
    if (ctl.mul_en) begin
      prod_q    <= prod;
      prod_hi_q <= ctl.mul_hi;
    end
    if (ctl.sum_clr) begin
      sum_q <= '0;
    end else if (ctl.acc_en) begin
      sum_q <= sum_q + addend;
    end
    if (ctl.add_en) begin
      wide_q <= WIDE_W'(accum_sel) + WIDE_W'(sum_q >>> FRAC_BITS);
    end
    if (done) begin
      drive_q <= clamp_w[DATA_W-1:0];
      cmd_q   <= pos_accum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_accum_q <= '0;
      pos_e1_q    <= '0;
      pos_e0_q    <= '0;
      spd_accum_q <= '0;
      spd_e1_q    <= '0;
      spd_e0_q    <= '0;
    end else if (ctl.clamp_en) begin
      if (loop == LOOP_POS) begin
        pos_accum_q <= clamp_w[DATA_W-1:0];
        pos_e1_q    <= e_q;
        pos_e0_q    <= pos_e1_q;
      end else begin
        spd_accum_q <= clamp_w[DATA_W-1:0];
        spd_e1_q    <= e_q;
        spd_e0_q    <= spd_e1_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {cmd_q, drive_q};

endmodule

>>> rtl/cip_checker.sv
`include "cascaded_incremental_pid_top_assert.svh"

module cip_checker
  import cip_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o
);

  logic out_wait;

  assign out_wait = m_axis_tvalid_o && !m_axis_tready_i;

  `CIP_ASSERT_NXT(a_out_hold, out_wait, m_axis_tvalid_o && $stable(m_axis_tdata_o))

  `CIP_ASSERT_NXT(a_busy_after_req, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  `CIP_ASSERT_IMP(a_result_from_busy, $rose(m_axis_tvalid_o), $past(!s_axis_tready_o))

  `CIP_ASSERT_IMP(a_cfg_always_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind cascaded_incremental_pid_top cip_checker u_cip_checker (.*);

>>> verif/tb_cascaded_incremental_pid_top.sv
`timescale 1ns / 1ps

module tb_cascaded_incremental_pid_top;
  import cip_pkg::*;

  localparam int unsigned FRAC         = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS = 60;
  localparam longint ERR_HI = (longint'(1) <<< 32) - 1;
  localparam longint ERR_LO = -(longint'(1) <<< 32);

  typedef struct {
    longint accum;
    longint err_last;
    longint err_before;
  } loop_state_t;

  typedef struct packed {
    logic [DATA_W-1:0] speed_command;
    logic [DATA_W-1:0] drive;
  } pid_result_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i  = '0;
  logic                 s_axis_tuser_i  = 1'b0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i     = '0;
  logic [DATA_W-1:0]    cfg_data_i      = '0;

  cascaded_incremental_pid_top #(
    .FRAC_BITS(FRAC)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  logic [GAIN_W-1:0]  pos_kp = '0, pos_ki = '0, pos_kd = '0;
  logic [GAIN_W-1:0]  spd_kp = '0, spd_ki = '0, spd_kd = '0;
  logic [LIMIT_W-1:0] pos_lim = '0, spd_lim = '0;
  loop_state_t        pos_loop = '{0, 0, 0};
  loop_state_t        spd_loop = '{0, 0, 0};

  pid_result_t pending_results[$];
  pid_result_t want, got;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          fail_count     = 0;
  int          request_count  = 0;
  int          result_count   = 0;
  int          cfg_writes     = 0;
  int          setting_count  = 0;
  int unsigned cycle_count    = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    case (idx)
      CFG_POS_KP:    pos_kp  = data[GAIN_W-1:0];
      CFG_POS_KI:    pos_ki  = data[GAIN_W-1:0];
      CFG_POS_KD:    pos_kd  = data[GAIN_W-1:0];
      CFG_SPD_KP:    spd_kp  = data[GAIN_W-1:0];
      CFG_SPD_KI:    spd_ki  = data[GAIN_W-1:0];
      CFG_SPD_KD:    spd_kd  = data[GAIN_W-1:0];
      CFG_POS_LIMIT: pos_lim = data[LIMIT_W-1:0];
      CFG_SPD_LIMIT: spd_lim = data[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic loop_state_t incremental_pid(loop_state_t s, longint err, longint kp,
                                                  longint ki, longint kd, longint lim);
    longint      e;
    longint      sum;
    longint      acc;
    loop_state_t n;
    e = err;
    if (e > ERR_HI) e = ERR_HI;
    if (e < ERR_LO) e = ERR_LO;
    sum = kp * (e - s.err_last) + ki * e + kd * (e - 2 * s.err_last + s.err_before);
    acc = s.accum + (sum >>> FRAC);
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    n.accum      = acc;
    n.err_before = s.err_last;
    n.err_last   = e;
    return n;
  endfunction

  function automatic pid_result_t cascade_tick(logic op, logic signed [DATA_W-1:0] target,
                                               logic signed [DATA_W-1:0] angle,
                                               logic signed [RPM_W-1:0] rpm);
    longint      sref;
    longint      fdb;
    pid_result_t r;
    fdb  = longint'(rpm) * (longint'(1) <<< FRAC);
    sref = longint'(target);
    if (op == OP_POSITION) begin
      pos_loop = incremental_pid(pos_loop, longint'(target) - longint'(angle),
                                 longint'(pos_kp), longint'(pos_ki), longint'(pos_kd),
                                 longint'(pos_lim));
      sref = pos_loop.accum;
    end
    spd_loop = incremental_pid(spd_loop, sref - fdb, longint'(spd_kp), longint'(spd_ki),
                               longint'(spd_kd), longint'(spd_lim));
    r.drive         = spd_loop.accum[DATA_W-1:0];
    r.speed_command = pos_loop.accum[DATA_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
    if (fail_count < 10) begin
      $display("Mismatch on %s at result %0d: expected %h, got %h", what, result_count, exp_v,
               act_v);
    end
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result drive", '0, got.drive);
      end else begin
        want = pending_results.pop_front();
        if (got.drive !== want.drive) report_mismatch("drive", want.drive, got.drive);
        if (got.speed_command !== want.speed_command) begin
          report_mismatch("speed_command", want.speed_command, got.speed_command);
        end
      end
      result_count++;
    end
  end

  task automatic send_request(logic op, logic [DATA_W-1:0] target, logic [DATA_W-1:0] angle,
                              logic [RPM_W-1:0] rpm);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {rpm, angle, target};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(cascade_tick(op, target, angle, rpm));
    request_count++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(idx, data);
    cfg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_gains(logic [DATA_W-1:0] pkp, logic [DATA_W-1:0] pki,
                               logic [DATA_W-1:0] pkd, logic [DATA_W-1:0] skp,
                               logic [DATA_W-1:0] ski, logic [DATA_W-1:0] skd,
                               logic [DATA_W-1:0] plim, logic [DATA_W-1:0] slim);
    wait_idle();
    cfg_write(CFG_POS_KP, pkp);
    cfg_write(CFG_POS_KI, pki);
    cfg_write(CFG_POS_KD, pkd);
    cfg_write(CFG_SPD_KP, skp);
    cfg_write(CFG_SPD_KI, ski);
    cfg_write(CFG_SPD_KD, skd);
    cfg_write(CFG_POS_LIMIT, plim);
    cfg_write(CFG_SPD_LIMIT, slim);
    setting_count++;
  endtask

  function automatic logic [DATA_W-1:0] random_q16();
    logic [DATA_W-1:0] r;
    r = $urandom();
    case ($urandom_range(3))
      0: return r;
      1: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          3: return 32'h0001_0000;
          default: return '0;
        endcase
      end
      default: return {{12{r[19]}}, r[19:0]};
    endcase
  endfunction

  function automatic logic [RPM_W-1:0] random_rpm();
    logic [DATA_W-1:0] r;
    r = $urandom();
    case ($urandom_range(3))
      0: return r[RPM_W-1:0];
      1: return r[0] ? 16'h7FFF : 16'h8000;
      default: return {{8{r[7]}}, r[7:0]};
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] random_gain();
    case ($urandom_range(3))
      0: return '0;
      1, 2: return $urandom_range(32'h0002_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] random_limit();
    case ($urandom_range(4))
      0: return '0;
      1: return $urandom();
      2: return 32'h7FFF_FFFF;
      default: return $urandom_range(32'h0100_0000);
    endcase
  endfunction

  task automatic test_reset_state();
    send_request(OP_POSITION, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000);
    send_request(OP_SPEED, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF);
  endtask

  task automatic test_register_masking();
    program_gains('1, '1, '1, '1, '1, '1, '1, '1);
    cfg_write(8'd8, 32'h0000_1234);
    cfg_write(8'hFF, $urandom());
    send_request(OP_POSITION, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000);
    send_request(OP_POSITION, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF);
    send_request(OP_SPEED, 32'h7FFF_FFFF, 32'h0000_0000, 16'h8000);
    send_request(OP_SPEED, 32'h8000_0000, 32'hFFFF_FFFF, 16'h7FFF);
  endtask

  task automatic test_unity_gains();
    program_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000,
                  32'h0000_8000, 32'h0000_4000, 32'h0064_0000, 32'h7FFF_FFFF);
    send_request(OP_POSITION, 32'h005A_0000, 32'h0000_0000, 16'd0);
    send_request(OP_POSITION, 32'h005A_0000, 32'h0010_0000, 16'd5);
    send_request(OP_POSITION, 32'h005A_0000, 32'h0030_0000, 16'd20);
    send_request(OP_POSITION, 32'hFFA6_0000, 32'h0040_0000, 16'hFFF6);
    send_request(OP_SPEED, 32'h0064_0000, 32'h1234_5678, 16'd50);
    send_request(OP_SPEED, 32'hFF9C_0000, 32'h8765_4321, 16'hFFCE);
    send_request(OP_POSITION, 32'h005A_0000, 32'h0058_8000, 16'd2);
    send_request(OP_POSITION, 32'h005A_0000, 32'h005A_0000, 16'd0);
  endtask

  task automatic test_zero_limit();
    program_gains(32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 32'h0001_0000,
                  32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0100_0000);
    send_request(OP_POSITION, 32'h0100_0000, 32'hFF00_0000, 16'd100);
    send_request(OP_POSITION, 32'hFF00_0000, 32'h0100_0000, 16'hFF9C);
    program_gains(32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 32'h0001_0000,
                  32'h0001_0000, 32'h0001_0000, 32'h0100_0000, 32'h0000_0000);
    send_request(OP_POSITION, 32'h0100_0000, 32'hFF00_0000, 16'd100);
    send_request(OP_SPEED, 32'hFF00_0000, 32'h0100_0000, 16'hFF9C);
  endtask

  // Most requests form servo runs: one mode and a held target, the angle at a
  // small random offset from it, a small rpm. The rest are unrelated noise.
  task automatic test_random_traffic();
    int                send_pct[4] = '{0, 71, 0, 31};
    int                recv_pct[4] = '{0, 0, 71, 31};
    int                run_left;
    logic              run_op;
    logic [DATA_W-1:0] run_target;
    logic [DATA_W-1:0] offset;
    for (int mode = 0; mode < 4; mode++) begin
      for (int s = 0; s < 2; s++) begin
        program_gains(random_gain(), random_gain(), random_gain(), random_gain(),
                      random_gain(), random_gain(), random_limit(), random_limit());
        cfg_write(CFG_IDX_W'($urandom_range(255, 8)), $urandom());
        send_idle_pct  = send_pct[mode];
        recv_stall_pct = recv_pct[mode];
        run_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
          if ($urandom_range(3) == 0) begin
            send_request(1'($urandom_range(1)), random_q16(), random_q16(), random_rpm());
          end else begin
            if (run_left == 0) begin
              run_left   = $urandom_range(12, 4);
              run_op     = 1'($urandom_range(1));
              run_target = random_q16();
            end
            offset = $urandom();
            send_request(run_op, run_target, run_target + {{14{offset[17]}}, offset[17:0]},
                         {{8{offset[25]}}, offset[25:18]});
            run_left--;
          end
        end
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_register_masking();
    test_unity_gains();
    test_zero_limit();
    test_random_traffic();
    wait_idle();
    $display("Sent %0d requests and checked %0d results in both servo modes.", request_count,
             result_count);
    $display("Made %0d register writes over %0d gain and limit settings, four pacing modes.",
             cfg_writes, setting_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, pending_results.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
